### rtl/jsv_pkg.sv
// Shared types, constants and helper functions for the JSON structure validator.
`default_nettype none

package jsv_pkg;

  // Nesting limit and the widths that follow from it.
  localparam int MAX_NESTING = 64;
  localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
  localparam int ADDR_W      = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  // Fixed field widths.
  localparam int TOKEN_W = 4;
  localparam int STATE_W = 5;
  localparam int NEST_W  = 7;
  localparam int ERR_W   = 3;
  localparam int RET_W   = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Token kinds delivered by the tokenizer.
  typedef enum logic [TOKEN_W-1:0] {
    TK_ARR_OPEN   = 4'd0,
    TK_ARR_CLOSE  = 4'd1,
    TK_OBJ_OPEN   = 4'd2,
    TK_OBJ_CLOSE  = 4'd3,
    TK_COLON      = 4'd4,
    TK_COMMA      = 4'd5,
    TK_STRING     = 4'd6,
    TK_VALUE      = 4'd7,
    TK_EOS        = 4'd8,
    TK_BLOCKSTR   = 4'd9,
    TK_COMMENT    = 4'd10,
    TK_BLKCOMMENT = 4'd11,
    TK_SPACE      = 4'd12,
    TK_NEWLINE    = 4'd13,
    TK_INVALID    = 4'd14
  } tok_t;

  // Grammar position, one-hot. The end-of-array and end-of-object positions
  // are passed through within one beat and never held.
  typedef enum logic [17:0] {
    ST_START_DOC  = 18'h00001,
    ST_VALUE_DOC  = 18'h00002,
    ST_END_DOC    = 18'h00004,
    ST_END_STREAM = 18'h00008,
    ST_START_ARR  = 18'h00010,
    ST_VALUE_ARR  = 18'h00020,
    ST_AFTER_ARR  = 18'h00040,
    ST_COMMA_ARR  = 18'h00080,
    ST_START_OBJ  = 18'h00200,
    ST_KEY        = 18'h00400,
    ST_AFTER_KEY  = 18'h00800,
    ST_COLON      = 18'h01000,
    ST_VALUE_OBJ  = 18'h02000,
    ST_AFTER_OBJ  = 18'h04000,
    ST_COMMA_OBJ  = 18'h08000,
    ST_FATAL      = 18'h20000
  } gstate_t;

  // Dense output codes of the grammar positions.
  localparam logic [STATE_W-1:0] CODE_START_DOC  = 5'd0;
  localparam logic [STATE_W-1:0] CODE_VALUE_DOC  = 5'd1;
  localparam logic [STATE_W-1:0] CODE_END_DOC    = 5'd2;
  localparam logic [STATE_W-1:0] CODE_END_STREAM = 5'd3;
  localparam logic [STATE_W-1:0] CODE_START_ARR  = 5'd4;
  localparam logic [STATE_W-1:0] CODE_VALUE_ARR  = 5'd5;
  localparam logic [STATE_W-1:0] CODE_AFTER_ARR  = 5'd6;
  localparam logic [STATE_W-1:0] CODE_COMMA_ARR  = 5'd7;
  localparam logic [STATE_W-1:0] CODE_START_OBJ  = 5'd9;
  localparam logic [STATE_W-1:0] CODE_KEY        = 5'd10;
  localparam logic [STATE_W-1:0] CODE_AFTER_KEY  = 5'd11;
  localparam logic [STATE_W-1:0] CODE_COLON      = 5'd12;
  localparam logic [STATE_W-1:0] CODE_VALUE_OBJ  = 5'd13;
  localparam logic [STATE_W-1:0] CODE_AFTER_OBJ  = 5'd14;
  localparam logic [STATE_W-1:0] CODE_COMMA_OBJ  = 5'd15;
  localparam logic [STATE_W-1:0] CODE_FATAL      = 5'd17;

  // Error codes reported with each result.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 3'd0,
    ERR_INVALID  = 3'd1,
    ERR_RECOVER  = 3'd2,
    ERR_FATAL    = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  // Position to return to when a nested array or object closes.
  typedef enum logic [RET_W-1:0] {
    RET_DOC = 2'd0,
    RET_ARR = 2'd1,
    RET_OBJ = 2'd2
  } ret_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ALLOW_COMMENTS       = 2'd0,
    REG_ALLOW_TRAILING_COMMA = 2'd1,
    REG_ALLOW_BLOCK_STRINGS  = 2'd2,
    REG_ALLOW_VALUES_AS_KEYS = 2'd3
  } reg_idx_t;

  // One result beat.
  typedef struct packed {
    logic [STATE_W-1:0] parse_state;
    logic [NEST_W-1:0]  nest_depth;
    logic [ERR_W-1:0]   error_code;
    logic               document_done;
  } result_t;

  // Maps a one-hot grammar position to its dense output code.
  function automatic logic [STATE_W-1:0] state_code(input gstate_t st);
    logic [STATE_W-1:0] code;
    unique case (st)
      ST_START_DOC:  code = CODE_START_DOC;
      ST_VALUE_DOC:  code = CODE_VALUE_DOC;
      ST_END_DOC:    code = CODE_END_DOC;
      ST_END_STREAM: code = CODE_END_STREAM;
      ST_START_ARR:  code = CODE_START_ARR;
      ST_VALUE_ARR:  code = CODE_VALUE_ARR;
      ST_AFTER_ARR:  code = CODE_AFTER_ARR;
      ST_COMMA_ARR:  code = CODE_COMMA_ARR;
      ST_START_OBJ:  code = CODE_START_OBJ;
      ST_KEY:        code = CODE_KEY;
      ST_AFTER_KEY:  code = CODE_AFTER_KEY;
      ST_COLON:      code = CODE_COLON;
      ST_VALUE_OBJ:  code = CODE_VALUE_OBJ;
      ST_AFTER_OBJ:  code = CODE_AFTER_OBJ;
      ST_COMMA_OBJ:  code = CODE_COMMA_OBJ;
      default:       code = CODE_FATAL;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### rtl/jsv_chan_if.sv
// Valid/ready stream interfaces for the token and result channels.
`default_nettype none

interface jsv_tok_if;
  logic                        valid;
  logic                        ready;
  logic [jsv_pkg::TOKEN_W-1:0] token_kind;

  modport source (output valid, output token_kind, input ready);
  modport sink   (input valid, input token_kind, output ready);
endinterface

interface jsv_res_if;
  logic                        valid;
  logic                        ready;
  logic [jsv_pkg::STATE_W-1:0] parse_state;
  logic [jsv_pkg::NEST_W-1:0]  nest_depth;
  logic [jsv_pkg::ERR_W-1:0]   error_code;
  logic                        document_done;

  modport source (output valid, output parse_state, output nest_depth,
                  output error_code, output document_done, input ready);
  modport sink   (input valid, input parse_state, input nest_depth,
                  input error_code, input document_done, output ready);
endinterface

`default_nettype wire

### rtl/jsv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module jsv_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/json_structure_validator_top.sv
// Top level of the JSON structure validator: grammar rules, nesting stack and result buffer.
//
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+------------------------------------------------
//  tok      | in        | valid / ready  | token_kind
//  res      | out       | valid / ready  | parse_state, nest_depth, error_code, document_done
//  APB      | in        | psel / penable | allow_* flags at byte addresses 0, 4, 8, 12
//
// One token is accepted per cycle while tok.ready is high; its result is then registered.
// The top return entry lives in a register and the entries below it in a RAM; the RAM is
// read ahead at the entry under the new top, with a bypass when that entry is
// written at the same edge, so pushes and pops can follow each other in every cycle.
// A two-entry result buffer keeps tok.ready high while one result waits on res.
// Synchronous reset clears the grammar position, the depth, the flags and the buffer;
// the stack RAM needs no clearing.
`default_nettype none

module json_structure_validator_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  jsv_tok_if.sink                              tok,
  jsv_res_if.source                            res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [jsv_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [jsv_pkg::PDATA_W-1:0]     pwdata,
  output logic      [jsv_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready
);

  // Configuration flags.
  logic allow_comments;
  logic allow_trailing_comma;
  logic allow_block_strings;
  logic allow_values_as_keys;

  // Grammar state and stack bookkeeping.
  jsv_pkg::gstate_t              gstate, gstate_next;
  logic [jsv_pkg::DEPTH_W-1:0]   depth, depth_next;
  logic [jsv_pkg::RET_W-1:0]     tos, tos_next;
  logic                          fwd_valid;
  logic [jsv_pkg::RET_W-1:0]     fwd_data;
  logic [jsv_pkg::RET_W-1:0]     ram_rdata;
  logic [jsv_pkg::RET_W-1:0]     below;

  // Result buffer: output register and skid entry.
  logic                          out_valid;
  jsv_pkg::result_t              out_data;
  logic                          skid_valid;
  jsv_pkg::result_t              skid_data;

  // Per-beat decode.
  logic                          accept;
  logic                          push;
  logic                          pop;
  logic                          fatal;
  logic                          overflow;
  jsv_pkg::ret_t                 push_ret;
  jsv_pkg::gstate_t              s;
  jsv_pkg::gstate_t              pop_st;
  logic                          pop_done;
  jsv_pkg::err_t                 err;
  logic                          done;
  logic                          depth_full;
  jsv_pkg::result_t              result;
  logic                          cfg_wr;

  // APB register file.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_comments       <= 1'b0;
      allow_trailing_comma <= 1'b0;
      allow_block_strings  <= 1'b0;
      allow_values_as_keys <= 1'b0;
    end else if (cfg_wr) begin
      unique case (jsv_pkg::reg_idx_t'(paddr[3:2]))
        jsv_pkg::REG_ALLOW_COMMENTS:       allow_comments       <= pwdata[0];
        jsv_pkg::REG_ALLOW_TRAILING_COMMA: allow_trailing_comma <= pwdata[0];
        jsv_pkg::REG_ALLOW_BLOCK_STRINGS:  allow_block_strings  <= pwdata[0];
        jsv_pkg::REG_ALLOW_VALUES_AS_KEYS: allow_values_as_keys <= pwdata[0];
        default:                           allow_comments       <= allow_comments;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (jsv_pkg::reg_idx_t'(paddr[3:2]))
      jsv_pkg::REG_ALLOW_COMMENTS:       prdata[0] = allow_comments;
      jsv_pkg::REG_ALLOW_TRAILING_COMMA: prdata[0] = allow_trailing_comma;
      jsv_pkg::REG_ALLOW_BLOCK_STRINGS:  prdata[0] = allow_block_strings;
      jsv_pkg::REG_ALLOW_VALUES_AS_KEYS: prdata[0] = allow_values_as_keys;
      default:                           prdata    = '0;
    endcase
  end

  // Input handshake: a new beat is taken unless both buffer entries are full.
  assign tok.ready = !skid_valid;
  assign accept    = tok.valid && tok.ready;

  // Entry under the top of stack: bypass the RAM when it was written at the last edge.
  assign below      = fwd_valid ? fwd_data : ram_rdata;
  assign depth_full = depth >= jsv_pkg::DEPTH_W'(jsv_pkg::MAX_NESTING);

  // Position reached when the top return entry is popped.
  always_comb begin
    pop_done = 1'b0;
    unique case (jsv_pkg::ret_t'(tos))
      jsv_pkg::RET_ARR: pop_st = jsv_pkg::ST_AFTER_ARR;
      jsv_pkg::RET_OBJ: pop_st = jsv_pkg::ST_AFTER_OBJ;
      default: begin
        pop_st   = jsv_pkg::ST_END_DOC;
        pop_done = 1'b1;
      end
    endcase
  end

  // Grammar rules for one token.
  always_comb begin
    s           = gstate;
    gstate_next = gstate;
    err         = jsv_pkg::ERR_OK;
    done        = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    fatal       = 1'b0;
    overflow    = 1'b0;
    push_ret    = jsv_pkg::RET_DOC;
    if (gstate == jsv_pkg::ST_FATAL) begin
      err = jsv_pkg::ERR_FATAL;
    end else begin
      // A scalar document is complete once the next token arrives.
      if (gstate == jsv_pkg::ST_VALUE_DOC) begin
        s = jsv_pkg::ST_END_DOC;
      end
      gstate_next = s;
      unique case (jsv_pkg::tok_t'(tok.token_kind))
        jsv_pkg::TK_ARR_OPEN, jsv_pkg::TK_OBJ_OPEN: begin
          if (s == jsv_pkg::ST_START_DOC) begin
            push_ret = jsv_pkg::RET_DOC;
          end else if (s == jsv_pkg::ST_COLON) begin
            push_ret = jsv_pkg::RET_OBJ;
          end else begin
            push_ret = jsv_pkg::RET_ARR;
          end
          if (s == jsv_pkg::ST_START_DOC || s == jsv_pkg::ST_COLON ||
              s == jsv_pkg::ST_START_ARR || s == jsv_pkg::ST_COMMA_ARR) begin
            if (depth_full) begin
              overflow = 1'b1;
            end else begin
              push        = 1'b1;
              gstate_next = (jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_ARR_OPEN) ?
                            jsv_pkg::ST_START_ARR : jsv_pkg::ST_START_OBJ;
            end
          end else begin
            fatal = 1'b1;
          end
        end
        jsv_pkg::TK_ARR_CLOSE: begin
          if (s == jsv_pkg::ST_START_ARR || s == jsv_pkg::ST_VALUE_ARR ||
              s == jsv_pkg::ST_AFTER_ARR || s == jsv_pkg::ST_COMMA_ARR) begin
            if (s == jsv_pkg::ST_COMMA_ARR && !allow_trailing_comma) begin
              err = jsv_pkg::ERR_RECOVER;
            end
            if (depth == '0) begin
              fatal = 1'b1;
            end else begin
              pop         = 1'b1;
              gstate_next = pop_st;
              done        = pop_done;
            end
          end else begin
            fatal = 1'b1;
          end
        end
        jsv_pkg::TK_OBJ_CLOSE: begin
          if (s == jsv_pkg::ST_START_OBJ || s == jsv_pkg::ST_VALUE_OBJ ||
              s == jsv_pkg::ST_AFTER_OBJ || s == jsv_pkg::ST_COMMA_OBJ) begin
            if (s == jsv_pkg::ST_COMMA_OBJ && !allow_trailing_comma) begin
              err = jsv_pkg::ERR_RECOVER;
            end
            if (depth == '0) begin
              fatal = 1'b1;
            end else begin
              pop         = 1'b1;
              gstate_next = pop_st;
              done        = pop_done;
            end
          end else begin
            fatal = 1'b1;
          end
        end
        jsv_pkg::TK_COLON: begin
          if (s == jsv_pkg::ST_KEY || s == jsv_pkg::ST_AFTER_KEY) begin
            gstate_next = jsv_pkg::ST_COLON;
          end else if (s == jsv_pkg::ST_START_OBJ || s == jsv_pkg::ST_COMMA_OBJ ||
                       s == jsv_pkg::ST_VALUE_OBJ || s == jsv_pkg::ST_AFTER_OBJ) begin
            gstate_next = jsv_pkg::ST_COLON;
            err         = jsv_pkg::ERR_RECOVER;
          end else begin
            fatal = 1'b1;
          end
        end
        jsv_pkg::TK_COMMA: begin
          if (s == jsv_pkg::ST_VALUE_ARR || s == jsv_pkg::ST_AFTER_ARR) begin
            gstate_next = jsv_pkg::ST_COMMA_ARR;
          end else if (s == jsv_pkg::ST_VALUE_OBJ || s == jsv_pkg::ST_AFTER_OBJ) begin
            gstate_next = jsv_pkg::ST_COMMA_OBJ;
          end else if (s == jsv_pkg::ST_START_ARR || s == jsv_pkg::ST_COMMA_ARR) begin
            gstate_next = jsv_pkg::ST_COMMA_ARR;
            err         = jsv_pkg::ERR_RECOVER;
          end else if (s == jsv_pkg::ST_START_OBJ || s == jsv_pkg::ST_COMMA_OBJ ||
                       s == jsv_pkg::ST_KEY || s == jsv_pkg::ST_AFTER_KEY) begin
            gstate_next = jsv_pkg::ST_COMMA_OBJ;
            err         = jsv_pkg::ERR_RECOVER;
          end else begin
            fatal = 1'b1;
          end
        end
        jsv_pkg::TK_STRING, jsv_pkg::TK_VALUE, jsv_pkg::TK_BLOCKSTR: begin
          if (jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_BLOCKSTR &&
              !allow_block_strings) begin
            err = jsv_pkg::ERR_INVALID;
          end else if (jsv_pkg::tok_t'(tok.token_kind) != jsv_pkg::TK_BLOCKSTR &&
                       (s == jsv_pkg::ST_START_OBJ || s == jsv_pkg::ST_COMMA_OBJ)) begin
            // Key position; an unquoted key needs its extension.
            gstate_next = jsv_pkg::ST_KEY;
            if (jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_VALUE &&
                !allow_values_as_keys) begin
              err = jsv_pkg::ERR_RECOVER;
            end
          end else if (jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_VALUE &&
                       (s == jsv_pkg::ST_VALUE_ARR || s == jsv_pkg::ST_VALUE_OBJ)) begin
            err = jsv_pkg::ERR_RECOVER;
          end else if (s == jsv_pkg::ST_START_DOC) begin
            gstate_next = jsv_pkg::ST_VALUE_DOC;
            done        = 1'b1;
          end else if (s == jsv_pkg::ST_START_ARR || s == jsv_pkg::ST_COMMA_ARR) begin
            gstate_next = jsv_pkg::ST_VALUE_ARR;
          end else if (s == jsv_pkg::ST_COLON) begin
            gstate_next = jsv_pkg::ST_VALUE_OBJ;
          end else if (jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_VALUE) begin
            fatal = 1'b1;
          end else begin
            err = jsv_pkg::ERR_RECOVER;
          end
        end
        jsv_pkg::TK_EOS: begin
          if (s == jsv_pkg::ST_START_DOC || s == jsv_pkg::ST_END_DOC ||
              s == jsv_pkg::ST_END_STREAM) begin
            gstate_next = jsv_pkg::ST_END_STREAM;
          end else begin
            fatal = 1'b1;
          end
        end
        jsv_pkg::TK_COMMENT, jsv_pkg::TK_BLKCOMMENT,
        jsv_pkg::TK_SPACE, jsv_pkg::TK_NEWLINE: begin
          if ((jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_COMMENT ||
               jsv_pkg::tok_t'(tok.token_kind) == jsv_pkg::TK_BLKCOMMENT) &&
              !allow_comments) begin
            err = jsv_pkg::ERR_INVALID;
          end else if (s == jsv_pkg::ST_VALUE_ARR) begin
            gstate_next = jsv_pkg::ST_AFTER_ARR;
          end else if (s == jsv_pkg::ST_KEY) begin
            gstate_next = jsv_pkg::ST_AFTER_KEY;
          end else if (s == jsv_pkg::ST_VALUE_OBJ) begin
            gstate_next = jsv_pkg::ST_AFTER_OBJ;
          end
        end
        default: begin
          err = jsv_pkg::ERR_INVALID;
        end
      endcase
      // Grammar violations and overflow end in the sticky error position.
      if (fatal) begin
        gstate_next = jsv_pkg::ST_FATAL;
        err         = jsv_pkg::ERR_FATAL;
      end else if (overflow) begin
        gstate_next = jsv_pkg::ST_FATAL;
        err         = jsv_pkg::ERR_OVERFLOW;
      end
    end
  end

  // Depth and top of stack after an accepted beat.
  always_comb begin
    depth_next = depth;
    tos_next   = tos;
    if (accept && push) begin
      depth_next = depth + jsv_pkg::DEPTH_W'(1);
      tos_next   = push_ret;
    end else if (accept && pop) begin
      depth_next = depth - jsv_pkg::DEPTH_W'(1);
      tos_next   = below;
    end
  end

  // Stack RAM: a push spills the old top below the new one; the read always
  // fetches the entry under the next top.
  jsv_ram #(
    .WIDTH (jsv_pkg::RET_W),
    .DEPTH (jsv_pkg::MAX_NESTING)
  ) u_stack_ram (
    .clk   (clk),
    .we    (accept && push && (depth != '0)),
    .waddr (jsv_pkg::ADDR_W'(depth - jsv_pkg::DEPTH_W'(1))),
    .wdata (tos),
    .raddr (jsv_pkg::ADDR_W'(depth_next - jsv_pkg::DEPTH_W'(2))),
    .rdata (ram_rdata)
  );

  // Grammar and stack registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate    <= jsv_pkg::ST_START_DOC;
      depth     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (accept) begin
        gstate <= gstate_next;
      end
      depth     <= depth_next;
      fwd_valid <= accept && push;
    end
  end

  always_ff @(posedge clk) begin
    tos      <= tos_next;
    fwd_data <= tos;
  end

  // Result of the current beat.
  always_comb begin
    result.parse_state   = jsv_pkg::state_code(gstate_next);
    result.nest_depth    = jsv_pkg::NEST_W'(depth_next);
    result.error_code    = err;
    result.document_done = done;
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= accept;
        end else begin
          out_valid  <= accept;
        end
      end else if (!out_valid) begin
        out_valid <= accept;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && res.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (accept) begin
          skid_data <= result;
        end
      end else if (accept) begin
        out_data <= result;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign res.valid         = out_valid;
  assign res.parse_state   = out_data.parse_state;
  assign res.nest_depth    = out_data.nest_depth;
  assign res.error_code    = out_data.error_code;
  assign res.document_done = out_data.document_done;

  // The stack never holds more than the nesting limit.
  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    depth <= jsv_pkg::DEPTH_W'(jsv_pkg::MAX_NESTING))
    else $error("nesting depth beyond limit");

  // The unrecoverable position is left only by reset.
  a_fatal_sticky: assert property (@(posedge clk) disable iff (rst)
    gstate == jsv_pkg::ST_FATAL |=> gstate == jsv_pkg::ST_FATAL)
    else $error("left the unrecoverable position");

  // The skid entry is only filled behind a waiting output register.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // An accepted open token that pushes raises the depth by one.
  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    accept && push |=> depth == $past(depth) + jsv_pkg::DEPTH_W'(1))
    else $error("push did not raise the depth");

endmodule

`default_nettype wire

### verif/json_structure_validator_top_tb.sv
// Self-checking testbench for the JSON structure validator: grammar-aware token stimulus, predictor and scoreboard.
`default_nettype none

module json_structure_validator_top_tb;
  import jsv_pkg::*;

  // Token code that the tokenizer never names; it must be rejected as invalid.
  localparam logic [TOKEN_W-1:0] TK_RESERVED = 4'd15;
  localparam int MAX_CYCLES   = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 500;
  localparam int DIRECTED_N   = 26;

  // Grammar position, nesting stack and extension flags of the predictor.
  typedef struct {
    logic [STATE_W-1:0] pos;
    logic [NEST_W-1:0]  depth;
    ret_t               stack [MAX_NESTING];
    logic [3:0]         flags;
  } grammar_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int cycle_count;
  grammar_t gen_model;
  logic [TOKEN_W-1:0] directed_seq [DIRECTED_N];

  jsv_tok_if tok_ch ();
  jsv_res_if res_ch ();

  json_structure_validator_top u_top (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Grammar state right after reset.
  function automatic void grammar_reset(output grammar_t g);
    g.pos   = CODE_START_DOC;
    g.depth = '0;
    g.flags = '0;
    foreach (g.stack[i]) g.stack[i] = RET_DOC;
  endfunction

  // Places a scalar in value position; returns 0 where no value may stand.
  function automatic bit value_slot(inout grammar_t g, inout result_t r);
    case (g.pos)
      CODE_START_DOC: begin
        g.pos = CODE_VALUE_DOC;
        r.document_done = 1'b1;
      end
      CODE_START_ARR, CODE_COMMA_ARR: g.pos = CODE_VALUE_ARR;
      CODE_COLON: g.pos = CODE_VALUE_OBJ;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Applies one token to the grammar and returns the result beat it causes.
  function automatic result_t grammar_step(inout grammar_t g,
                                           input logic [TOKEN_W-1:0] kind);
    result_t r;
    logic [STATE_W-1:0] s;
    logic [STATE_W-1:0] open_st;
    logic [STATE_W-1:0] mid_st;
    logic [STATE_W-1:0] after_st;
    logic [STATE_W-1:0] comma_st;
    ret_t ret;
    bit legal;
    r.error_code = ERR_OK;
    r.document_done = 1'b0;
    if (g.pos == CODE_FATAL) begin
      r.error_code = ERR_FATAL;
    end else begin
      // A scalar document counts as ended once the next token shows up.
      if (g.pos == CODE_VALUE_DOC) g.pos = CODE_END_DOC;
      s = g.pos;
      case (kind)
        TK_ARR_OPEN, TK_OBJ_OPEN: begin
          legal = 1'b1;
          ret = RET_DOC;
          case (s)
            CODE_START_DOC: ret = RET_DOC;
            CODE_COLON: ret = RET_OBJ;
            CODE_START_ARR, CODE_COMMA_ARR: ret = RET_ARR;
            default: legal = 1'b0;
          endcase
          if (!legal) begin
            g.pos = CODE_FATAL;
            r.error_code = ERR_FATAL;
          end else if (g.depth >= MAX_NESTING) begin
            g.pos = CODE_FATAL;
            r.error_code = ERR_OVERFLOW;
          end else begin
            g.stack[g.depth] = ret;
            g.depth = g.depth + 1'b1;
            g.pos = (kind == TK_ARR_OPEN) ? CODE_START_ARR : CODE_START_OBJ;
          end
        end
        TK_ARR_CLOSE, TK_OBJ_CLOSE: begin
          if (kind == TK_ARR_CLOSE) begin
            open_st = CODE_START_ARR;
            mid_st = CODE_VALUE_ARR;
            after_st = CODE_AFTER_ARR;
            comma_st = CODE_COMMA_ARR;
          end else begin
            open_st = CODE_START_OBJ;
            mid_st = CODE_VALUE_OBJ;
            after_st = CODE_AFTER_OBJ;
            comma_st = CODE_COMMA_OBJ;
          end
          legal = (s == open_st) || (s == mid_st) || (s == after_st) || (s == comma_st);
          if (s == comma_st && !g.flags[REG_ALLOW_TRAILING_COMMA]) r.error_code = ERR_RECOVER;
          if (!legal || g.depth == 0) begin
            g.pos = CODE_FATAL;
            r.error_code = ERR_FATAL;
          end else begin
            g.depth = g.depth - 1'b1;
            case (g.stack[g.depth])
              RET_ARR: g.pos = CODE_AFTER_ARR;
              RET_OBJ: g.pos = CODE_AFTER_OBJ;
              default: begin
                g.pos = CODE_END_DOC;
                r.document_done = 1'b1;
              end
            endcase
          end
        end
        TK_COLON: begin
          case (s)
            CODE_KEY, CODE_AFTER_KEY: g.pos = CODE_COLON;
            CODE_START_OBJ, CODE_COMMA_OBJ, CODE_VALUE_OBJ, CODE_AFTER_OBJ: begin
              g.pos = CODE_COLON;
              r.error_code = ERR_RECOVER;
            end
            default: begin
              g.pos = CODE_FATAL;
              r.error_code = ERR_FATAL;
            end
          endcase
        end
        TK_COMMA: begin
          case (s)
            CODE_VALUE_ARR, CODE_AFTER_ARR: g.pos = CODE_COMMA_ARR;
            CODE_VALUE_OBJ, CODE_AFTER_OBJ: g.pos = CODE_COMMA_OBJ;
            CODE_START_ARR, CODE_COMMA_ARR: begin
              g.pos = CODE_COMMA_ARR;
              r.error_code = ERR_RECOVER;
            end
            CODE_START_OBJ, CODE_COMMA_OBJ, CODE_KEY, CODE_AFTER_KEY: begin
              g.pos = CODE_COMMA_OBJ;
              r.error_code = ERR_RECOVER;
            end
            default: begin
              g.pos = CODE_FATAL;
              r.error_code = ERR_FATAL;
            end
          endcase
        end
        TK_STRING: begin
          if (s == CODE_START_OBJ || s == CODE_COMMA_OBJ) g.pos = CODE_KEY;
          else if (!value_slot(g, r)) r.error_code = ERR_RECOVER;
        end
        TK_VALUE: begin
          if (s == CODE_START_OBJ || s == CODE_COMMA_OBJ) begin
            g.pos = CODE_KEY;
            if (!g.flags[REG_ALLOW_VALUES_AS_KEYS]) r.error_code = ERR_RECOVER;
          end else if (s == CODE_VALUE_ARR || s == CODE_VALUE_OBJ) begin
            r.error_code = ERR_RECOVER;
          end else if (!value_slot(g, r)) begin
            g.pos = CODE_FATAL;
            r.error_code = ERR_FATAL;
          end
        end
        TK_EOS: begin
          if (s == CODE_START_DOC || s == CODE_END_DOC || s == CODE_END_STREAM) begin
            g.pos = CODE_END_STREAM;
          end else begin
            g.pos = CODE_FATAL;
            r.error_code = ERR_FATAL;
          end
        end
        TK_BLOCKSTR: begin
          if (!g.flags[REG_ALLOW_BLOCK_STRINGS]) r.error_code = ERR_INVALID;
          else if (!value_slot(g, r)) r.error_code = ERR_RECOVER;
        end
        TK_COMMENT, TK_BLKCOMMENT, TK_SPACE, TK_NEWLINE: begin
          // Comments are whitespace only while their extension is on.
          if ((kind == TK_COMMENT || kind == TK_BLKCOMMENT) && !g.flags[REG_ALLOW_COMMENTS]) begin
            r.error_code = ERR_INVALID;
          end else begin
            case (s)
              CODE_VALUE_ARR: g.pos = CODE_AFTER_ARR;
              CODE_KEY: g.pos = CODE_AFTER_KEY;
              CODE_VALUE_OBJ: g.pos = CODE_AFTER_OBJ;
              default: ;
            endcase
          end
        end
        default: r.error_code = ERR_INVALID;
      endcase
    end
    r.parse_state = g.pos;
    r.nest_depth = g.depth;
    return r;
  endfunction

  // Picks the next token that steers toward nesting one level deeper or toward closing one level.
  function automatic logic [TOKEN_W-1:0] steer_token(input grammar_t g, input bit deepen);
    case (g.pos)
      CODE_START_ARR, CODE_COMMA_ARR: return deepen ? TK_ARR_OPEN : TK_ARR_CLOSE;
      CODE_COLON: return deepen ? TK_OBJ_OPEN : TK_VALUE;
      CODE_VALUE_ARR, CODE_AFTER_ARR: return deepen ? TK_COMMA : TK_ARR_CLOSE;
      CODE_START_OBJ, CODE_COMMA_OBJ: return deepen ? TK_STRING : TK_OBJ_CLOSE;
      CODE_KEY, CODE_AFTER_KEY: return TK_COLON;
      CODE_VALUE_OBJ, CODE_AFTER_OBJ: return deepen ? TK_COMMA : TK_OBJ_CLOSE;
      default: return TK_EOS;
    endcase
  endfunction

  // Holds the predicted result beats and compares them with what comes out.
  class result_scoreboard;
    grammar_t model;
    result_t pending [$];
    int errors;

    function new();
      grammar_reset(model);
      errors = 0;
    endfunction

    function void set_flag(input reg_idx_t idx, input logic value);
      model.flags[idx] = value;
    endfunction

    function void note_token(input logic [TOKEN_W-1:0] kind);
      pending.insert(pending.size(), grammar_step(model, kind));
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, got %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.parse_state !== exp.parse_state) begin
        $display("%0t: parse_state expected %0d got %0d", $time, exp.parse_state,
                 got.parse_state);
        errors++;
      end
      if (got.nest_depth !== exp.nest_depth) begin
        $display("%0t: nest_depth expected %0d got %0d", $time, exp.nest_depth,
                 got.nest_depth);
        errors++;
      end
      if (got.error_code !== exp.error_code) begin
        $display("%0t: error_code expected %0d got %0d", $time, exp.error_code,
                 got.error_code);
        errors++;
      end
      if (got.document_done !== exp.document_done) begin
        $display("%0t: document_done expected %0d got %0d", $time, exp.document_done,
                 got.document_done);
        errors++;
      end
    endfunction
  endclass

  result_scoreboard sb = new();

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("json_structure_validator_top_tb: errors");
      $finish;
    end
  end

  // Monitor both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        sb.check_result({res_ch.parse_state, res_ch.nest_depth, res_ch.error_code,
                         res_ch.document_done});
      end
      if (tok_ch.valid && tok_ch.ready) sb.note_token(tok_ch.token_kind);
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one token beat, with random gaps before it, and waits for acceptance.
  task automatic send_token(input logic [TOKEN_W-1:0] kind);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      tok_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tok_ch.valid <= 1'b1;
    tok_ch.token_kind <= kind;
    @(posedge clk);
    while (!tok_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Commits a token to the stimulus model and sends it.
  task automatic emit(input logic [TOKEN_W-1:0] kind);
    void'(grammar_step(gen_model, kind));
    send_token(kind);
  endtask

  // Drops valid and waits until every expected beat has come back.
  task automatic wait_idle();
    tok_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup phase, then access phase.
  task automatic write_reg(input reg_idx_t idx, input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    sb.set_flag(idx, value);
    gen_model.flags[idx] = value;
  endtask

  // Writes all four extension flags once the block is idle.
  task automatic set_config(input logic [3:0] bits);
    wait_idle();
    for (int i = 0; i < 4; i++) write_reg(reg_idx_t'(i), bits[i]);
  endtask

  // Random tokens that keep the outer container open and never go fatal.
  // Most of them are well formed; the rest are recoverable or invalid noise.
  // Above the cap only tokens that do not nest deeper are taken.
  task automatic run_random(input int count, input int cap);
    int sent;
    logic [TOKEN_W-1:0] kind;
    grammar_t trial;
    result_t r;
    bit ok;
    sent = 0;
    while (sent < count) begin
      kind = TOKEN_W'($urandom_range(0, 15));
      trial = gen_model;
      r = grammar_step(trial, kind);
      ok = (trial.pos != CODE_FATAL) && (trial.depth >= 1) &&
           ((trial.depth <= cap) || (trial.depth <= gen_model.depth));
      if (ok && r.error_code != ERR_OK && $urandom_range(0, 99) < 75) ok = 1'b0;
      if (ok) begin
        emit(kind);
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    tok_ch.valid = 1'b0;
    tok_ch.token_kind = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b0;
    grammar_reset(gen_model);
    directed_seq = '{TK_SPACE, TK_COMMENT, TK_INVALID, TK_RESERVED, TK_ARR_OPEN,
                     TK_OBJ_OPEN, TK_COLON, TK_VALUE, TK_VALUE, TK_STRING,
                     TK_NEWLINE, TK_COMMA, TK_VALUE, TK_SPACE, TK_COLON,
                     TK_ARR_OPEN, TK_BLOCKSTR, TK_STRING, TK_COMMA, TK_ARR_CLOSE,
                     TK_COMMA, TK_OBJ_CLOSE, TK_BLKCOMMENT, TK_COMMA, TK_ARR_OPEN,
                     TK_ARR_CLOSE};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extensions off: misplaced colon, value after value, unquoted
    // key, trailing commas and disabled comments and block strings.
    set_config(4'b0000);
    foreach (directed_seq[i]) emit(directed_seq[i]);

    // Sender sparse, receiver mostly stalled, all extensions on.
    set_config(4'b1111);
    send_idle_pct = 37;
    recv_idle_pct = 84;
    run_random(RANDOM_ITEMS, $urandom_range(4, 40));

    // Roles swapped, random flags.
    set_config(4'($urandom_range(0, 15)));
    send_idle_pct = 84;
    recv_idle_pct = 37;
    run_random(RANDOM_ITEMS, $urandom_range(4, 40));

    // Full rate, starting with a long receiver hold-off that backs up the input.
    set_config(4'($urandom_range(0, 15)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_random(RANDOM_ITEMS, $urandom_range(4, 40));

    // The run has one reset, so it ends in one of the terminal paths: nesting
    // overflow, or closing the document, end of stream and then a fatal token.
    set_config(4'($urandom_range(0, 15)));
    if ($urandom_range(0, 1) == 1) begin
      while (gen_model.pos != CODE_FATAL) emit(steer_token(gen_model, 1'b1));
    end else begin
      while (gen_model.pos != CODE_END_DOC) emit(steer_token(gen_model, 1'b0));
      emit(TK_EOS);
      emit(TK_STRING);
      emit(TK_EOS);
      emit(TK_OBJ_OPEN);
    end
    // Once fatal, every token must report the sticky error.
    repeat (8) emit(TOKEN_W'($urandom_range(0, 15)));

    wait_idle();
    if (sb.errors == 0) begin
      $display("json_structure_validator_top_tb: clean");
    end else begin
      $display("json_structure_validator_top_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
